FILE: hdl/hmf_pkg.sv
// ----------------------------------------------------------------------------
// hmf_pkg: shared types and constants of the haptic misalignment feedback core
// Fixed widths of the force paths, the controller states, the command and
// status groups between controller and datapath, and the register map.
// ----------------------------------------------------------------------------
package hmf_pkg;

    localparam int FIX_W     = 32;
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

    // Projection divide: 96-bit dividend, 64-bit divisor, quotient below 2^33.
    localparam int NUM_W     = 96;
    localparam int DEN_W     = 64;
    localparam int QUO_W     = 34;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int GAIN_W    = 21;
    localparam int WEIGHT_W  = 17;
    localparam int MAG_W     = 16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [GAIN_W-1:0]   GAIN_RST    = GAIN_W'(65536);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST  = WEIGHT_W'(655);
    localparam logic [MAG_W-1:0]    MIN_MAG_RST = MAG_W'(1);

    typedef enum logic [1:0] {
        REG_GAIN    = 2'd0,
        REG_WEIGHT  = 2'd1,
        REG_MIN_MAG = 2'd2
    } t_reg_idx;

    typedef logic [AXES-1:0][FIX_W-1:0] t_vec;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain;
        logic [WEIGHT_W-1:0] weight;
        logic [MAG_W-1:0]    min_mag;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC_MUL,
        S_MAC_ACC,
        S_CHECK,
        S_NUM_LO,
        S_NUM_HI,
        S_NUM_ADD,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_PERP,
        S_GAIN,
        S_DIFF,
        S_STEP,
        S_UPDATE,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        TERM_HH,
        TERM_AA,
        TERM_HA
    } t_term;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_MUL,
        DP_ACC,
        DP_MAG,
        DP_NUM_LO,
        DP_NUM_HI,
        DP_NUM_ADD,
        DP_DIV_LOAD,
        DP_DIV_STEP,
        DP_PERP,
        DP_GAIN,
        DP_DIFF,
        DP_STEP,
        DP_UPDATE,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        t_term               term;
        logic [AXIS_W-1:0]   axis;
    } t_dp_cmd;

    typedef struct packed {
        logic below_min;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: hdl/hmf_in_if.sv
// ----------------------------------------------------------------------------
// hmf_in_if: force input channel
// Valid/ready channel carrying the human and assistant force vectors.
// ----------------------------------------------------------------------------
interface hmf_in_if import hmf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [FIX_W-1:0] human_x;
    logic signed [FIX_W-1:0] human_y;
    logic signed [FIX_W-1:0] human_z;
    logic signed [FIX_W-1:0] assist_x;
    logic signed [FIX_W-1:0] assist_y;
    logic signed [FIX_W-1:0] assist_z;

    modport source (
        output valid, human_x, human_y, human_z, assist_x, assist_y, assist_z,
        input  ready
    );
    modport sink (
        input  valid, human_x, human_y, human_z, assist_x, assist_y, assist_z,
        output ready
    );
endinterface

FILE: hdl/hmf_out_if.sv
// ----------------------------------------------------------------------------
// hmf_out_if: feedback output channel
// Valid/ready channel carrying the filtered feedback force vector.
// ----------------------------------------------------------------------------
interface hmf_out_if import hmf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [FIX_W-1:0] feedback_x;
    logic signed [FIX_W-1:0] feedback_y;
    logic signed [FIX_W-1:0] feedback_z;

    modport source (
        output valid, feedback_x, feedback_y, feedback_z,
        input  ready
    );
    modport sink (
        input  valid, feedback_x, feedback_y, feedback_z,
        output ready
    );
endinterface

FILE: hdl/hmf_regs.sv
// ----------------------------------------------------------------------------
// hmf_regs: configuration registers
// APB-style register file holding gain, smoothing weight and magnitude limit.
// ----------------------------------------------------------------------------
module hmf_regs import hmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain    <= GAIN_RST;
            r_cfg.weight  <= WEIGHT_RST;
            r_cfg.min_mag <= MIN_MAG_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GAIN:    r_cfg.gain    <= pwdata[GAIN_W-1:0];
                REG_WEIGHT:  r_cfg.weight  <= pwdata[WEIGHT_W-1:0];
                REG_MIN_MAG: r_cfg.min_mag <= pwdata[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GAIN:    prdata = APB_DATA_W'(r_cfg.gain);
            REG_WEIGHT:  prdata = APB_DATA_W'(r_cfg.weight);
            REG_MIN_MAG: prdata = APB_DATA_W'(r_cfg.min_mag);
            default:     prdata = '0;
        endcase
    end

endmodule

FILE: hdl/hmf_div.sv
// ----------------------------------------------------------------------------
// hmf_div: restoring divider for the projection term
// One quotient bit per step; the dividend's top part is preloaded as the
// remainder because the quotient is known to fit in QUO_W bits.
// ----------------------------------------------------------------------------
module hmf_div import hmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_step,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quot
);

    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;
    logic [DEN_W-1:0] n_rem;

    // The quotient register doubles as the shift register for the low dividend bits.
    assign trial     = {r_rem, r_quo[QUO_W-1]};
    assign fits      = trial >= {1'b0, i_den};
    assign trial_sub = trial - {1'b0, i_den};
    assign n_rem     = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
    assign o_quot    = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= DEN_W'(i_num[NUM_W-1:QUO_W]);
            r_quo <= i_num[QUO_W-1:0];
        end else if (i_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load || i_step) && (i_den != '0) |=> r_rem < $past(i_den))
        else $error("divider remainder not below divisor");

endmodule

FILE: hdl/hmf_ctrl.sv
// ----------------------------------------------------------------------------
// hmf_ctrl: sequencing controller
// Steps the datapath through the dot products, the threshold check and,
// per axis, the projection divide, gain, and low-pass update.
// ----------------------------------------------------------------------------
module hmf_ctrl import hmf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state            r_state, n_state;
    t_term             r_term, n_term;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term  <= TERM_HH;
            r_axis  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            r_axis  <= n_axis;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_term  = r_term;
        n_axis  = r_axis;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MAC_MUL;
                    n_term  = TERM_HH;
                    n_axis  = '0;
                end
            end
            S_MAC_MUL: n_state = S_MAC_ACC;
            S_MAC_ACC: begin
                if (r_axis == LAST_AXIS) begin
                    n_axis = '0;
                    unique case (r_term)
                        TERM_HH: begin
                            n_term  = TERM_AA;
                            n_state = S_MAC_MUL;
                        end
                        TERM_AA: begin
                            n_term  = TERM_HA;
                            n_state = S_MAC_MUL;
                        end
                        default: n_state = S_CHECK;
                    endcase
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_MAC_MUL;
                end
            end
            S_CHECK: begin
                n_axis  = '0;
                n_state = i_sts.below_min ? S_IDLE : S_NUM_LO;
            end
            S_NUM_LO:   n_state = S_NUM_HI;
            S_NUM_HI:   n_state = S_NUM_ADD;
            S_NUM_ADD:  n_state = S_DIV_LOAD;
            S_DIV_LOAD: begin
                n_cnt   = '0;
                n_state = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_PERP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_PERP:  n_state = S_GAIN;
            S_GAIN:  n_state = S_DIFF;
            S_DIFF:  n_state = S_STEP;
            S_STEP:  n_state = S_UPDATE;
            S_UPDATE: begin
                if (r_axis == LAST_AXIS) begin
                    n_state = S_EMIT;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_NUM_LO;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.term = r_term;
        o_cmd.axis = r_axis;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE:     o_cmd.op = i_in_valid ? DP_CAPTURE : DP_NOP;
            S_MAC_MUL:  o_cmd.op = DP_MUL;
            S_MAC_ACC:  o_cmd.op = DP_ACC;
            S_CHECK:    o_cmd.op = DP_MAG;
            S_NUM_LO:   o_cmd.op = DP_NUM_LO;
            S_NUM_HI:   o_cmd.op = DP_NUM_HI;
            S_NUM_ADD:  o_cmd.op = DP_NUM_ADD;
            S_DIV_LOAD: o_cmd.op = DP_DIV_LOAD;
            S_DIV_RUN:  o_cmd.op = DP_DIV_STEP;
            S_PERP:     o_cmd.op = DP_PERP;
            S_GAIN:     o_cmd.op = DP_GAIN;
            S_DIFF:     o_cmd.op = DP_DIFF;
            S_STEP:     o_cmd.op = DP_STEP;
            S_UPDATE:   o_cmd.op = DP_UPDATE;
            S_EMIT:     o_cmd.op = i_sts.out_free ? DP_EMIT : DP_NOP;
            default:    o_cmd.op = DP_NOP;
        endcase
    end

    a_div_full_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PERP |->
            $past(r_state) == S_DIV_RUN && $past(r_cnt) == CNT_W'(DIV_STEPS - 1))
        else $error("projection used before the divider finished");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis <= LAST_AXIS)
        else $error("axis counter out of range");

endmodule

FILE: hdl/hmf_dp.sv
// ----------------------------------------------------------------------------
// hmf_dp: arithmetic datapath
// Holds the item, the dot-product accumulators, the shared 33x33 multiplier,
// the divider, the gain and filter stages, the filter state and the
// output register.
// ----------------------------------------------------------------------------
module hmf_dp import hmf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    input  t_cfg    i_cfg,
    input  t_vec    i_human,
    input  t_vec    i_assist,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_vec    o_out
);

    localparam logic signed [44:0] SAT_HI = 45'sd2147483647;
    localparam logic signed [44:0] SAT_LO = -45'sd2147483648;

    t_vec                     r_h, r_a, r_y, r_out;
    logic                     r_out_valid;
    logic [63:0]              r_hh, r_aa, r_dmag;
    logic signed [65:0]       r_dot;
    logic                     r_dneg;
    logic [31:0]              r_thr;
    logic signed [65:0]       r_prod;
    logic [NUM_W-1:0]         r_num;
    logic signed [35:0]       r_perp;
    logic signed [57:0]       r_gprod;
    logic signed [41:0]       r_diff;
    logic signed [59:0]       r_sprod;

    logic signed [FIX_W-1:0]  h_i, a_i, y_i;
    logic [FIX_W-1:0]         a_mag;
    logic signed [32:0]       mul_a, mul_b;
    logic signed [65:0]       mul_p;
    logic [65:0]              dot_abs;
    logic [QUO_W-1:0]         quot;
    logic [35:0]              q_ext;
    logic signed [35:0]       proj;
    logic signed [35:0]       n_perp;
    logic signed [21:0]       gain_s;
    logic [57:0]              g_mag, g_sum;
    logic signed [41:0]       f_val;
    logic signed [41:0]       n_diff;
    logic [WEIGHT_W-1:0]      w_eff;
    logic signed [WEIGHT_W:0] w_s;
    logic [59:0]              s_mag, s_sum;
    logic signed [44:0]       step_val, sum_val;
    logic signed [FIX_W-1:0]  n_y;

    assign h_i   = r_h[i_cmd.axis];
    assign a_i   = r_a[i_cmd.axis];
    assign y_i   = r_y[i_cmd.axis];
    assign a_mag = a_i[FIX_W-1] ? FIX_W'(-a_i) : FIX_W'(a_i);

    always_comb begin
        unique case (i_cmd.op)
            DP_NUM_LO: begin
                mul_a = {1'b0, r_dmag[31:0]};
                mul_b = {1'b0, a_mag};
            end
            DP_NUM_HI: begin
                mul_a = {1'b0, r_dmag[63:32]};
                mul_b = {1'b0, a_mag};
            end
            default: begin
                unique case (i_cmd.term)
                    TERM_HH: begin
                        mul_a = 33'(h_i);
                        mul_b = 33'(h_i);
                    end
                    TERM_AA: begin
                        mul_a = 33'(a_i);
                        mul_b = 33'(a_i);
                    end
                    default: begin
                        mul_a = 33'(h_i);
                        mul_b = 33'(a_i);
                    end
                endcase
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign dot_abs = r_dot[65] ? 66'(-r_dot) : 66'(r_dot);

    hmf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cmd.op == DP_DIV_LOAD),
        .i_step  (i_cmd.op == DP_DIV_STEP),
        .i_num   (r_num),
        .i_den   (r_aa),
        .o_quot  (quot)
    );

    // The quotient is the rounded magnitude; the sign comes from the dot
    // product and the assistant component. A zero assistant vector drops it.
    assign q_ext  = 36'(quot);
    assign proj   = (r_aa == '0) ? '0
                  : ((r_dneg ^ a_i[FIX_W-1]) ? -signed'(q_ext) : signed'(q_ext));
    assign n_perp = 36'(h_i) - proj;

    assign gain_s = {1'b0, i_cfg.gain};

    // f = -round(gain * perp / 2^16), ties away from zero.
    assign g_mag  = r_gprod[57] ? 58'(-r_gprod) : 58'(r_gprod);
    assign g_sum  = g_mag + 58'd32768;
    assign f_val  = r_gprod[57] ? signed'(g_sum[57:16]) : -signed'(g_sum[57:16]);
    assign n_diff = f_val - 42'(y_i);

    assign w_eff  = i_cfg.weight[WEIGHT_W-1] ? WEIGHT_ONE : i_cfg.weight;
    assign w_s    = {1'b0, w_eff};

    assign s_mag    = r_sprod[59] ? 60'(-r_sprod) : 60'(r_sprod);
    assign s_sum    = s_mag + 60'd32768;
    assign step_val = r_sprod[59] ? -signed'({1'b0, s_sum[59:16]})
                                  : signed'({1'b0, s_sum[59:16]});
    assign sum_val  = step_val + 45'(y_i);

    always_comb begin
        priority if (sum_val > SAT_HI) begin
            n_y = SAT_HI[FIX_W-1:0];
        end else if (sum_val < SAT_LO) begin
            n_y = SAT_LO[FIX_W-1:0];
        end else begin
            n_y = sum_val[FIX_W-1:0];
        end
    end

    assign o_sts.below_min = (r_hh < 64'(r_thr)) || (r_aa < 64'(r_thr));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    // Filter state and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_UPDATE) begin
                r_y[i_cmd.axis] <= n_y;
            end
            if (i_cmd.op == DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_CAPTURE: begin
                r_h   <= i_human;
                r_a   <= i_assist;
                r_hh  <= '0;
                r_aa  <= '0;
                r_dot <= '0;
                r_thr <= {16'b0, i_cfg.min_mag} * {16'b0, i_cfg.min_mag};
            end
            DP_MUL:    r_prod <= mul_p;
            DP_ACC: begin
                unique case (i_cmd.term)
                    TERM_HH: r_hh  <= r_hh + r_prod[63:0];
                    TERM_AA: r_aa  <= r_aa + r_prod[63:0];
                    default: r_dot <= r_dot + r_prod;
                endcase
            end
            DP_MAG: begin
                r_dneg <= r_dot[65];
                r_dmag <= dot_abs[63:0];
            end
            DP_NUM_LO: r_prod <= mul_p;
            DP_NUM_HI: begin
                r_prod <= mul_p;
                r_num  <= NUM_W'(r_prod[63:0]) + NUM_W'(r_aa[63:1]);
            end
            DP_NUM_ADD: r_num   <= r_num + {r_prod[63:0], 32'b0};
            DP_PERP:    r_perp  <= n_perp;
            DP_GAIN:    r_gprod <= gain_s * r_perp;
            DP_DIFF:    r_diff  <= n_diff;
            DP_STEP:    r_sprod <= w_s * r_diff;
            DP_EMIT:    r_out   <= r_y;
            default: ;
        endcase
    end

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_PERP) && (r_aa != '0) |-> !quot[QUO_W-1])
        else $error("projection quotient exceeds its bound");

endmodule

FILE: hdl/haptic_misalignment_feedback_core.sv
// ----------------------------------------------------------------------------
// haptic_misalignment_feedback_core: misalignment feedback force generator
// Each transaction on i_force brings a human and an assistant force vector
// (signed Q16.16). When both squared magnitudes reach min_magnitude squared,
// the human force component perpendicular to the assistant force is scaled
// by minus feedback_gain, low-pass filtered with smoothing_weight, and the
// saturated filter output leaves on o_feedback; otherwise no transaction
// follows and the filter keeps its state. One item is in work at a time; a
// weak-force item ends after the threshold check. The time per item is set
// by the single shared 33x33 multiplier for the nine dot-product terms and,
// above all, by the bit-serial projection divider, which runs 34 steps for
// each of the three axes. The finished vector sits in an output register,
// so a new item is accepted while the previous result waits. Registers sit
// at byte addresses 0 (feedback_gain), 4 (smoothing_weight) and 8
// (min_magnitude); the user must see that they are written only while the
// block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module haptic_misalignment_feedback_core import hmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hmf_in_if.sink                i_force,
    hmf_out_if.source             o_feedback,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    cfg;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_vec    human, assist, out_vec;
    logic    out_valid;

    assign human  = {i_force.human_z, i_force.human_y, i_force.human_x};
    assign assist = {i_force.assist_z, i_force.assist_y, i_force.assist_x};

    assign o_feedback.valid      = out_valid;
    assign o_feedback.feedback_x = out_vec[0];
    assign o_feedback.feedback_y = out_vec[1];
    assign o_feedback.feedback_z = out_vec[2];

    hmf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_force.valid),
        .o_in_ready (i_force.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    hmf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_cfg       (cfg),
        .i_human     (human),
        .i_assist    (assist),
        .i_out_ready (o_feedback.ready),
        .o_out_valid (out_valid),
        .o_out       (out_vec)
    );

endmodule

FILE: tb/hmf_feedback_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hmf_feedback_monitor: prediction and comparison for the feedback core
// Watches the force, feedback and register channels. It keeps its own copy of
// the settings and of the filter state, predicts the feedback vector for each
// accepted force transaction and compares every feedback transaction with the
// oldest prediction. Register reads are compared with the tracked settings.
// ----------------------------------------------------------------------------
module hmf_feedback_monitor import hmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hmf_in_if                     i_force_mon,
    hmf_out_if                    i_feedback_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    o_errors,
    output int                    o_pending
);

    localparam longint FIX_MAX = 64'sd2147483647;
    localparam longint FIX_MIN = -64'sd2147483648;

    logic [GAIN_W-1:0]       gain_cfg;
    logic [WEIGHT_W-1:0]     weight_cfg;
    logic [MAG_W-1:0]        min_mag_cfg;
    logic signed [FIX_W-1:0] filt_state [AXES];

    t_vec     feedback_q [$];
    t_vec     want_fb;
    t_vec     got_fb;
    t_vec     new_fb;
    logic     fresh;
    t_reg_idx reg_idx;
    logic [APB_DATA_W-1:0] want_rd;
    logic     rd_known;
    int       err_count = 0;

    assign o_errors  = err_count;
    assign o_pending = feedback_q.size();

    // Divide by 2^16, rounding to nearest with ties away from zero.
    function automatic longint q16_round(longint x);
        longint unsigned m;
        m = (x < 0) ? -x : x;
        m = (m + 64'd32768) >> 16;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_fix(longint x);
        if (x > FIX_MAX) return FIX_MAX;
        if (x < FIX_MIN) return FIX_MIN;
        return x;
    endfunction

    // Advances the filter for one force pair and returns the new output, if any.
    task automatic filter_step(input t_vec human, input t_vec assist,
                               output logic produced, output t_vec fb);
        longint             h [AXES];
        longint             a [AXES];
        logic [65:0]        hh;
        logic [65:0]        aa;
        logic [65:0]        thr;
        logic [65:0]        dmag;
        logic signed [66:0] dot;
        logic [127:0]       num;
        logic [127:0]       quo;
        longint             w;
        longint             proj;
        longint             perp;
        longint             f;
        longint             diff;
        logic               neg;
        produced = 1'b0;
        fb       = '0;
        hh       = '0;
        aa       = '0;
        dot      = '0;
        for (int i = 0; i < AXES; i++) begin
            h[i] = longint'($signed(human[i]));
            a[i] = longint'($signed(assist[i]));
            hh  += 66'(h[i] * h[i]);
            aa  += 66'(a[i] * a[i]);
            dot += 67'(h[i] * a[i]);
        end
        thr = 66'(min_mag_cfg) * 66'(min_mag_cfg);
        if (hh < thr || aa < thr) return;

        dmag = (dot < 0) ? 66'(-dot) : 66'(dot);
        w    = (weight_cfg > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight_cfg);
        for (int i = 0; i < AXES; i++) begin
            proj = 0;
            // A zero assistant vector has no direction: the projection is dropped.
            if (aa != 0) begin
                neg  = (dot < 0) != (a[i] < 0);
                num  = 128'(dmag) * 128'((a[i] < 0) ? -a[i] : a[i]) + 128'(aa >> 1);
                quo  = num / 128'(aa);
                proj = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
            end
            perp = h[i] - proj;
            f    = -q16_round(longint'(gain_cfg) * perp);
            diff = f - longint'(filt_state[i]);
            filt_state[i] = FIX_W'(clamp_fix(longint'(filt_state[i]) + q16_round(w * diff)));
            fb[i] = filt_state[i];
        end
        produced = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain_cfg    <= GAIN_RST;
            weight_cfg  <= WEIGHT_RST;
            min_mag_cfg <= MIN_MAG_RST;
            for (int i = 0; i < AXES; i++) filt_state[i] = '0;
            feedback_q.delete();
        end else begin
            if (i_feedback_mon.valid && i_feedback_mon.ready) begin
                got_fb = {i_feedback_mon.feedback_z, i_feedback_mon.feedback_y,
                          i_feedback_mon.feedback_x};
                if (feedback_q.size() == 0) begin
                    $display("%0t: feedback transaction with none predicted: %h",
                             $time, got_fb);
                    err_count++;
                end else begin
                    want_fb = feedback_q.pop_front();
                    for (int i = 0; i < AXES; i++) begin
                        if (got_fb[i] !== want_fb[i]) begin
                            $display("%0t: feedback axis %0d: expected %0d, actual %0d",
                                     $time, i, $signed(want_fb[i]), $signed(got_fb[i]));
                            err_count++;
                        end
                    end
                end
            end

            if (i_force_mon.valid && i_force_mon.ready) begin
                filter_step({i_force_mon.human_z, i_force_mon.human_y, i_force_mon.human_x},
                            {i_force_mon.assist_z, i_force_mon.assist_y,
                             i_force_mon.assist_x},
                            fresh, new_fb);
                if (fresh) feedback_q = {feedback_q, new_fb};
            end

            if (psel && penable && pready) begin
                reg_idx  = t_reg_idx'(paddr[3:2]);
                rd_known = (paddr[1:0] == 2'b00);
                want_rd  = '0;
                if (rd_known) begin
                    case (reg_idx)
                        REG_GAIN: begin
                            if (pwrite) gain_cfg <= pwdata[GAIN_W-1:0];
                            want_rd = APB_DATA_W'(gain_cfg);
                        end
                        REG_WEIGHT: begin
                            if (pwrite) weight_cfg <= pwdata[WEIGHT_W-1:0];
                            want_rd = APB_DATA_W'(weight_cfg);
                        end
                        REG_MIN_MAG: begin
                            if (pwrite) min_mag_cfg <= pwdata[MAG_W-1:0];
                            want_rd = APB_DATA_W'(min_mag_cfg);
                        end
                        default: rd_known = 1'b0;
                    endcase
                end
                if (!pwrite && rd_known && prdata !== want_rd) begin
                    $display("%0t: register read at %h: expected %h, actual %h",
                             $time, paddr, want_rd, prdata);
                    err_count++;
                end
            end
        end
    end

endmodule

FILE: tb/tb_haptic_misalignment_feedback_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_haptic_misalignment_feedback_core: testbench of the feedback core
// Drives force transactions with random gaps and stalls the feedback channel
// at random. A directed set covers the field extremes, weak forces, a zero
// assistant vector, saturation and out-of-range settings; then random phases
// run under random settings. The monitor predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_haptic_misalignment_feedback_core;
    import hmf_pkg::*;

    localparam int          ITEMS_PER_PHASE = 125;
    localparam int          PHASES          = 6;
    localparam int          DRAIN           = 40;
    localparam int          CYCLE_LIMIT     = 1_000_000;
    localparam logic [31:0] FMAX            = 32'h7FFF_FFFF;
    localparam logic [31:0] FMIN            = 32'h8000_0000;
    localparam logic [31:0] ONE             = 32'h0001_0000;
    localparam logic [31:0] GAIN_TOP        = 32'h001F_FFFF;
    localparam logic [31:0] WEIGHT_TOP      = 32'h0001_FFFF;
    localparam logic [31:0] MIN_MAG_TOP     = 32'h0000_FFFF;
    // One word past the last register.
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = APB_ADDR_W'(12);

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    mon_errors;
    int                    mon_pending;
    int                    cycle_count = 0;
    logic                  src_burst   = 1'b0;
    logic                  sink_burst  = 1'b0;

    hmf_in_if  force_if ();
    hmf_out_if fb_if ();

    haptic_misalignment_feedback_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_force    (force_if),
        .o_feedback (fb_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    hmf_feedback_monitor u_monitor (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_force_mon    (force_if),
        .i_feedback_mon (fb_if),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_errors       (mon_errors),
        .o_pending      (mon_pending)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_vec mk_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        return {z, y, x};
    endfunction

    // 0: any value, 1: near unit magnitude, 2: a few LSBs, 3: extremes.
    function automatic logic [31:0] rand_comp(int unsigned kind);
        case (kind)
            0: return $urandom();
            1: return 32'(int'($urandom_range(0, 262144)) - 131072);
            2: return 32'(int'($urandom_range(0, 6)) - 3);
            default: begin
                case ($urandom_range(0, 4))
                    0: return FMAX;
                    1: return FMIN;
                    2: return '0;
                    3: return 32'd1;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    function automatic t_vec rand_vec(int unsigned kind);
        return mk_vec(rand_comp(kind), rand_comp(kind), rand_comp(kind));
    endfunction

    function automatic logic [APB_ADDR_W-1:0] reg_addr(t_reg_idx idx);
        return APB_ADDR_W'({idx, 2'b00});
    endfunction

    // Starts and ends at a falling edge.
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic program_reg(input logic [APB_ADDR_W-1:0] addr,
                               input logic [APB_DATA_W-1:0] data);
        apb_access(1'b1, addr, data);
        apb_access(1'b0, addr, '0);
    endtask

    task automatic push_force(input t_vec human, input t_vec assist);
        int gap;
        if ($urandom_range(0, 15) == 0) src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            force_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        force_if.valid    = 1'b1;
        force_if.human_x  = human[0];
        force_if.human_y  = human[1];
        force_if.human_z  = human[2];
        force_if.assist_x = assist[0];
        force_if.assist_y = assist[1];
        force_if.assist_z = assist[2];
        do @(posedge clk); while (!force_if.ready);
        @(negedge clk);
    endtask

    task automatic random_force();
        t_vec hv;
        t_vec av;
        int   sh;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                hv = rand_vec(0);
                av = rand_vec(0);
            end
            4, 5: begin
                hv = rand_vec(1);
                av = rand_vec(1);
            end
            6: begin
                // Nearly parallel pair: the perpendicular part is tiny.
                av = rand_vec(0);
                sh = $urandom_range(0, 8);
                for (int i = 0; i < AXES; i++)
                    hv[i] = 32'($signed(av[i]) >>> sh) ^ 32'($urandom_range(0, 3));
            end
            7: begin
                hv = rand_vec(3);
                av = rand_vec(3);
            end
            8: begin
                hv = rand_vec(2);
                av = rand_vec(0);
            end
            default: begin
                hv = rand_vec(0);
                av = rand_vec(0);
                av[$urandom_range(0, 2)] = '0;
                hv[$urandom_range(0, 2)] = '0;
            end
        endcase
        push_force(hv, av);
    endtask

    // Lets the block finish all work before the settings change.
    task automatic settle();
        force_if.valid = 1'b0;
        while (mon_pending != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    initial begin
        fb_if.ready = 1'b0;
        forever begin
            int stall;
            if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                fb_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            fb_if.ready = 1'b1;
            do @(posedge clk); while (fb_if.valid !== 1'b1);
            @(negedge clk);
        end
    end

    initial begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        force_if.valid    = 1'b0;
        force_if.human_x  = '0;
        force_if.human_y  = '0;
        force_if.human_z  = '0;
        force_if.assist_x = '0;
        force_if.assist_y = '0;
        force_if.assist_z = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: extremes, perpendicular and weak forces.
        push_force(mk_vec(FMAX, FMAX, FMAX), mk_vec(FMIN, FMIN, FMIN));
        push_force(mk_vec(FMIN, FMIN, FMIN), mk_vec(FMAX, FMIN, FMAX));
        push_force(mk_vec(FMAX, '0, FMIN), mk_vec('0, FMAX, '0));
        push_force(mk_vec('0, '0, '0), mk_vec(ONE, '0, '0));
        push_force(mk_vec(ONE, '0, '0), mk_vec('0, '0, '0));
        push_force(mk_vec(32'd1, '0, '0), mk_vec('0, '1, '0));
        push_force(mk_vec(FMIN, FMAX, 32'd1), mk_vec(32'd1, '0, '0));
        push_force(mk_vec(3 * ONE, 4 * ONE, '0), mk_vec(ONE, ONE, ONE));

        // Weight above one and the largest gain drive the output to saturation.
        settle();
        program_reg(reg_addr(REG_WEIGHT), WEIGHT_TOP);
        program_reg(reg_addr(REG_GAIN), GAIN_TOP);
        push_force(mk_vec(FMAX, FMIN, FMAX), mk_vec(32'd1, 32'd2, 32'd3));
        push_force(mk_vec(FMIN, FMAX, FMIN), mk_vec('1, '0, 32'd5));

        // A zero threshold lets a zero assistant vector through.
        settle();
        program_reg(reg_addr(REG_MIN_MAG), '0);
        program_reg(reg_addr(REG_WEIGHT), 32'(WEIGHT_ONE));
        push_force(mk_vec(32'd12345, 32'hFFFF_E57B, '0), mk_vec('0, '0, '0));
        push_force(mk_vec('0, '0, '0), mk_vec('0, '0, '0));

        // Largest threshold: exactly at it passes, just below it does not.
        settle();
        program_reg(reg_addr(REG_MIN_MAG), MIN_MAG_TOP);
        program_reg(reg_addr(REG_GAIN), '0);
        push_force(mk_vec(MIN_MAG_TOP, '0, '0), mk_vec('0, MIN_MAG_TOP, '0));
        push_force(mk_vec(MIN_MAG_TOP - 1, '0, '0), mk_vec(FMAX, '0, '0));
        push_force(mk_vec(32'd40000, 32'd40000, '0), mk_vec(FMAX, FMIN, '0));

        // Zero weight holds the filter; a write past the map changes nothing.
        settle();
        program_reg(reg_addr(REG_WEIGHT), '0);
        program_reg(reg_addr(REG_GAIN), 32'h0010_0000);
        program_reg(reg_addr(REG_MIN_MAG), 32'(MIN_MAG_RST));
        program_reg(ADDR_SPARE, '1);
        push_force(mk_vec(FMAX, 32'd77, FMIN), mk_vec(ONE, '0, ONE));
        push_force(rand_vec(0), rand_vec(0));

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case ($urandom_range(0, 4))
                0: program_reg(reg_addr(REG_GAIN), '0);
                1: program_reg(reg_addr(REG_GAIN), 32'(GAIN_RST));
                2: program_reg(reg_addr(REG_GAIN), 32'h0010_0000);
                3: program_reg(reg_addr(REG_GAIN), GAIN_TOP);
                default: program_reg(reg_addr(REG_GAIN), $urandom());
            endcase
            case ($urandom_range(0, 5))
                0: program_reg(reg_addr(REG_WEIGHT), '0);
                1: program_reg(reg_addr(REG_WEIGHT), 32'd1);
                2: program_reg(reg_addr(REG_WEIGHT), 32'(WEIGHT_RST));
                3: program_reg(reg_addr(REG_WEIGHT), 32'(WEIGHT_ONE));
                4: program_reg(reg_addr(REG_WEIGHT), $urandom());
                default: program_reg(reg_addr(REG_WEIGHT), $urandom_range(0, 65536));
            endcase
            case ($urandom_range(0, 4))
                0: program_reg(reg_addr(REG_MIN_MAG), '0);
                1: program_reg(reg_addr(REG_MIN_MAG), 32'(MIN_MAG_RST));
                2: program_reg(reg_addr(REG_MIN_MAG), MIN_MAG_TOP);
                3: program_reg(reg_addr(REG_MIN_MAG), $urandom());
                default: program_reg(reg_addr(REG_MIN_MAG), $urandom_range(0, 512));
            endcase
            repeat (ITEMS_PER_PHASE) random_force();
        end

        force_if.valid = 1'b0;
        while (mon_pending != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        if (mon_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
